FILE: rtl/rgb_c3_pkg.sv
// ----------------------------------------------------------------------------
// rgb_c3_pkg: shared types and constants of the 3x3 RGB convolution filter
// Pixel, column and product types, register indexes and default sizes.
// ----------------------------------------------------------------------------
package rgb_c3_pkg;

	// Default sizes for the top-level parameters.
	localparam int DEF_MAX_WIDTH      = 1024;
	localparam int DEF_COEF_FRAC_BITS = 11;

	// Kernel is square with this many taps per side.
	localparam int KSIZE = 3;

	// Saturation limit of one output channel.
	localparam logic [7:0] CH_MAX = 8'd255;

	// Product of an 8-bit channel and a signed 16-bit weight fits 24 bits.
	localparam int PW = 24;
	// Sum of nine products.
	localparam int SW = 28;

	// Input item kinds.
	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_DRAIN = 1'b1;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_KTOP   = 3'd2,
		REG_KMID   = 3'd3,
		REG_KBOT   = 3'd4
	} reg_idx_t;

	// Packed red|green|blue pixel.
	typedef logic [23:0] pix_t;

	// One column of the 3x3 window: rows r-2, r-1 and r.
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	// Signed weights of one kernel column, one per kernel row.
	typedef struct packed {
		logic signed [15:0] top;
		logic signed [15:0] mid;
		logic signed [15:0] bot;
	} wcol_t;

	typedef logic signed [PW-1:0] prod_t;
	// Nine products of one column, index is row * 3 + channel.
	typedef prod_t [8:0] prod_col_t;

	// Slot of the previous row in the three-row line store.
	function automatic logic [1:0] slot_prev(input logic [1:0] s);
		logic [1:0] p;
		p = (s == 2'd0) ? 2'd2 : s - 2'd1;
		return p;
	endfunction

	// Slot of the next row in the three-row line store.
	function automatic logic [1:0] slot_next(input logic [1:0] s);
		logic [1:0] n;
		n = (s == 2'd2) ? 2'd0 : s + 2'd1;
		return n;
	endfunction

endpackage

FILE: rtl/rgb_c3_line_mem.sv
// ----------------------------------------------------------------------------
// rgb_c3_line_mem: one row of the line store
// Single write port and one registered read port, one pixel per entry.
// ----------------------------------------------------------------------------
module rgb_c3_line_mem
	import rgb_c3_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_WIDTH,
	parameter int AW    = $clog2(DEF_MAX_WIDTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  pix_t          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output pix_t          rdata
);

	pix_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/rgb_c3_cell.sv
// ----------------------------------------------------------------------------
// rgb_c3_cell: one column cell of the convolution window
// Holds a window column, hands it to the next cell on shift and weights it.
// ----------------------------------------------------------------------------
module rgb_c3_cell
	import rgb_c3_pkg::*;
(
	input  logic      clk,
	input  logic      shift,
	input  col_t      col_in,
	input  wcol_t     wts,
	output col_t      col_out,
	output prod_col_t prod
);

	col_t col_q;

	// Column register; moves one place along the chain per pixel transfer.
	always_ff @(posedge clk) begin
		if (shift) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;

	// Weight every channel of every row in this column.
	always_comb begin
		pix_t               p;
		logic signed [15:0] w;
		logic signed [24:0] m;
		for (int i = 0; i < KSIZE; i++) begin
			case (i)
				0:       begin p = col_q.top; w = wts.top; end
				1:       begin p = col_q.mid; w = wts.mid; end
				default: begin p = col_q.bot; w = wts.bot; end
			endcase
			for (int ch = 0; ch < 3; ch++) begin
				m = $signed({1'b0, p[16 - 8*ch +: 8]}) * w;
				prod[i*3 + ch] = m[PW-1:0];
			end
		end
	end

endmodule

FILE: rtl/rgb_conv3x3_filter.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_filter: streaming 3x3 convolution filter for RGB images
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the in_ channel (func = 0) and the filtered
// image leaves in raster order on the out_ channel, one row behind. Interior
// pixels get a 3x3 weighted sum per channel, clamped to 0..255; border rows
// and columns pass through. After the last pixel of a frame, drain items
// (func = 1) each release one pixel of the last row.
// The cfg_ port writes width, height and the three kernel rows; a width or
// height write restarts the frame. Write it only while the block is idle.
// Throughput is one input item per cycle while in_stall is low. An item that
// causes two results (the last pixel of a row) holds the output register for
// the second. The first pixel of the next row causes no result and its empty
// slot makes up for it; drain items queued behind such a pair can see in_stall.
// From its input transfer the first result passes through five
// registers: line store read (loaded at the transfer edge), window shift,
// multiply, sum and output register. The window is a chain of three column
// cells fed from a three-row line store that has one read port per row.
// Reset clears counters and pipeline valids and restores register defaults
// (identity kernel); the line store is not cleared. When the receiver stalls,
// the result holds and the pipeline fills, then in_stall rises.
// ----------------------------------------------------------------------------
module rgb_conv3x3_filter
	import rgb_c3_pkg::*;
#(
	parameter int MAX_WIDTH      = DEF_MAX_WIDTH,
	parameter int COEF_FRAC_BITS = DEF_COEF_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [47:0] cfg_data,
	// Input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        func,
	input  logic [7:0]  red,
	input  logic [7:0]  green,
	input  logic [7:0]  blue,
	// Output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        last_of_run,
	output logic        frame_end
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = $clog2(MAX_WIDTH + 1);

	// Configuration registers
	logic [10:0] width_q;
	logic [15:0] height_q;
	logic [47:0] ktop_q, kmid_q, kbot_q;

	// Position and drain state
	logic [CW-1:0] col_q;
	logic [15:0]   row_q;
	logic [1:0]    slot_q;
	logic [CW-1:0] dcnt_q;
	logic [1:0]    dslot_q;

	logic [CW-1:0] eff_w;
	logic [15:0]   eff_h;
	logic [CW-1:0] col_nx;
	logic          row_end, last_row, drain_ok, is_drain, in_acc;
	logic [CW-1:0] drain_col;
	logic [AW-1:0] rd_addr;
	pix_t          in_pix;
	pix_t          rd [3];

	// Pipeline stage 1: after the line store read
	logic       v_s1, drn_s1, e1_s1, e2_s1, int_s1, fend_s1;
	logic [1:0] seltop_s1, selmid_s1;
	pix_t       pix_s1;
	col_t       col_new;

	// Pipeline stage 2: window loaded
	logic v_s2, e1_s2, e2_s2, int_s2, fend_s2;
	pix_t p2_s2;

	// Pipeline stage 3: products
	logic      v_s3, e1_s3, e2_s3, int_s3, fend_s3;
	pix_t      p1_s3, p2_s3;
	prod_col_t prod_s3 [KSIZE];

	// Pipeline stage 4: sums
	logic                 v_s4, e1_s4, e2_s4, int_s4, fend_s4;
	pix_t                 p1_s4, p2_s4;
	logic signed [SW-1:0] sum_s4 [3];

	// Output register
	logic o_v_q, o_two_q, o_fend_q;
	pix_t o_a_q, o_b_q;

	logic rdy_o, rdy4, rdy3, rdy2, rdy1;
	logic shift;

	col_t      cell_col [KSIZE];
	prod_col_t cell_prod [KSIZE];
	wcol_t     cell_w [KSIZE];

	pix_t flt_pix;

	// Clamp a sum to 0..255 after dropping the fraction.
	function automatic logic [7:0] clamp_ch(input logic signed [SW-1:0] acc);
		logic [SW-1:0] sh;
		logic [7:0]    r;
		sh = $unsigned(acc) >> COEF_FRAC_BITS;
		if (acc < 0) begin
			r = 8'd0;
		end else if (|sh[SW-1:8]) begin
			r = CH_MAX;
		end else begin
			r = sh[7:0];
		end
		return r;
	endfunction

	// Effective image size.
	always_comb begin
		if (width_q == 11'd0) begin
			eff_w = CW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = CW'(MAX_WIDTH);
		end else begin
			eff_w = CW'(width_q);
		end
		eff_h = (height_q == 16'd0) ? 16'd1 : height_q;
	end

	// Position decode for the item on the input.
	assign in_acc    = in_valid && !in_stall;
	assign is_drain  = (func == FUNC_DRAIN);
	assign col_nx    = col_q + CW'(1);
	assign row_end   = (col_nx == eff_w);
	assign last_row  = ({1'b0, row_q} + 17'd1 >= {1'b0, eff_h});
	assign drain_ok  = (dcnt_q != '0) && (dcnt_q <= eff_w);
	assign drain_col = eff_w - dcnt_q;
	assign rd_addr   = is_drain ? drain_col[AW-1:0] : col_q[AW-1:0];
	assign in_pix    = {red, green, blue};

	// Configuration writes and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd1024;
			height_q <= 16'd1;
			ktop_q   <= 48'd0;
			kmid_q   <= 48'd134217728;
			kbot_q   <= 48'd0;
			col_q    <= '0;
			row_q    <= '0;
			slot_q   <= '0;
			dcnt_q   <= '0;
			dslot_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH: begin
					width_q <= cfg_data[10:0];
					col_q   <= '0;
					row_q   <= '0;
					slot_q  <= '0;
					dcnt_q  <= '0;
				end
				REG_HEIGHT: begin
					height_q <= cfg_data[15:0];
					col_q    <= '0;
					row_q    <= '0;
					slot_q   <= '0;
					dcnt_q   <= '0;
				end
				REG_KTOP: ktop_q <= cfg_data;
				REG_KMID: kmid_q <= cfg_data;
				REG_KBOT: kbot_q <= cfg_data;
				default: ;
			endcase
		end else if (in_acc) begin
			if (is_drain) begin
				dcnt_q <= drain_ok ? dcnt_q - CW'(1) : '0;
			end else begin
				dcnt_q <= '0;
				if (row_end) begin
					col_q <= '0;
					if (last_row) begin
						row_q   <= '0;
						slot_q  <= '0;
						dcnt_q  <= eff_w;
						dslot_q <= slot_q;
					end else begin
						row_q  <= row_q + 16'd1;
						slot_q <= slot_next(slot_q);
					end
				end else begin
					col_q <= col_nx;
				end
			end
		end
	end

	// Line store: one memory per row slot, all read at the same column.
	for (genvar k = 0; k < 3; k++) begin : g_row
		rgb_c3_line_mem #(
			.DEPTH (MAX_WIDTH),
			.AW    (AW)
		) u_mem (
			.clk   (clk),
			.we    (in_acc && !is_drain && (slot_q == 2'(k))),
			.waddr (col_q[AW-1:0]),
			.wdata (in_pix),
			.re    (in_acc),
			.raddr (rd_addr),
			.rdata (rd[k])
		);
	end

	// Ready chain: a stage takes new data when empty or when it moves on.
	assign rdy_o    = !o_v_q || (!out_stall && !o_two_q);
	assign rdy4     = !v_s4 || rdy_o;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	// Stage 1 control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_acc;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (rdy1) begin
			drn_s1    <= is_drain;
			pix_s1    <= in_pix;
			e1_s1     <= !is_drain && (row_q != 16'd0) && (col_q != '0);
			e2_s1     <= is_drain ? drain_ok : ((row_q != 16'd0) && row_end);
			int_s1    <= (row_q >= 16'd2) && (col_q >= CW'(2));
			fend_s1   <= is_drain && (dcnt_q == CW'(1));
			seltop_s1 <= slot_prev(slot_prev(slot_q));
			selmid_s1 <= is_drain ? dslot_q : slot_prev(slot_q);
		end
	end

	// New window column from the two stored rows and the incoming pixel.
	always_comb begin
		case (seltop_s1)
			2'd0:    col_new.top = rd[0];
			2'd1:    col_new.top = rd[1];
			default: col_new.top = rd[2];
		endcase
		case (selmid_s1)
			2'd0:    col_new.mid = rd[0];
			2'd1:    col_new.mid = rd[1];
			default: col_new.mid = rd[2];
		endcase
		col_new.bot = pix_s1;
	end

	assign shift = rdy2 && v_s1 && !drn_s1;

	// Kernel columns: the newest cell holds the right column.
	for (genvar j = 0; j < KSIZE; j++) begin : g_cell
		assign cell_w[j].top = ktop_q[16*(KSIZE-1-j) +: 16];
		assign cell_w[j].mid = kmid_q[16*(KSIZE-1-j) +: 16];
		assign cell_w[j].bot = kbot_q[16*(KSIZE-1-j) +: 16];
		rgb_c3_cell u_cell (
			.clk     (clk),
			.shift   (shift),
			.col_in  ((j == 0) ? col_new : cell_col[(j == 0) ? 0 : j-1]),
			.wts     (cell_w[j]),
			.col_out (cell_col[j]),
			.prod    (cell_prod[j])
		);
	end

	// Stage 2.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			e1_s2   <= e1_s1;
			e2_s2   <= e2_s1;
			int_s2  <= int_s1;
			fend_s2 <= fend_s1;
			p2_s2   <= col_new.mid;
		end
	end

	// Stage 3: register the products; items without results drop here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2 && (e1_s2 || e2_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			e1_s3   <= e1_s2;
			e2_s3   <= e2_s2;
			int_s3  <= int_s2;
			fend_s3 <= fend_s2;
			p1_s3   <= cell_col[1].mid;
			p2_s3   <= p2_s2;
			for (int j = 0; j < KSIZE; j++) begin
				prod_s3[j] <= cell_prod[j];
			end
		end
	end

	// Stage 4: sum nine products per channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [SW-1:0] acc;
		if (rdy4) begin
			e1_s4   <= e1_s3;
			e2_s4   <= e2_s3;
			int_s4  <= int_s3;
			fend_s4 <= fend_s3;
			p1_s4   <= p1_s3;
			p2_s4   <= p2_s3;
			for (int ch = 0; ch < 3; ch++) begin
				acc = '0;
				for (int j = 0; j < KSIZE; j++) begin
					for (int i = 0; i < KSIZE; i++) begin
						acc = acc + SW'(prod_s3[j][i*3 + ch]);
					end
				end
				sum_s4[ch] <= acc;
			end
		end
	end

	// Filtered or border value of the first result.
	assign flt_pix = int_s4
		? {clamp_ch(sum_s4[0]), clamp_ch(sum_s4[1]), clamp_ch(sum_s4[2])}
		: p1_s4;

	// Output register; a second result follows the first transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v_q    <= 1'b0;
			o_two_q  <= 1'b0;
			o_fend_q <= 1'b0;
		end else if (rdy_o) begin
			o_v_q    <= v_s4;
			o_two_q  <= v_s4 && e1_s4 && e2_s4;
			o_fend_q <= v_s4 && fend_s4;
		end else if (!out_stall && o_two_q) begin
			o_two_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o) begin
			o_a_q <= e1_s4 ? flt_pix : p2_s4;
			o_b_q <= p2_s4;
		end else if (!out_stall && o_two_q) begin
			o_a_q <= o_b_q;
		end
	end

	assign out_valid   = o_v_q;
	assign out_red     = o_a_q[23:16];
	assign out_green   = o_a_q[15:8];
	assign out_blue    = o_a_q[7:0];
	assign last_of_run = !o_two_q;
	assign frame_end   = o_fend_q;

endmodule

FILE: rtl/rgb_c3_checker.sv
// ----------------------------------------------------------------------------
// rgb_c3_checker: port-level checks of the 3x3 RGB convolution filter
// Watches the output channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module rgb_c3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  out_red,
	input logic [7:0]  out_green,
	input logic [7:0]  out_blue,
	input logic        last_of_run,
	input logic        frame_end
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_red)
			&& $stable(out_green) && $stable(out_blue)
			&& $stable(last_of_run) && $stable(frame_end))
		else $error("stalled result changed");

	// The end of a frame is always the last result of its item.
	a_fend_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> last_of_run)
		else $error("frame end on a result that is not last of run");

	// The second result of a pixel follows its first without a gap.
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_run |=> out_valid && last_of_run)
		else $error("second result of a pair missing");

	// Handshake outputs are always known once out of reset.
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({out_valid, in_stall}))
		else $error("unknown value on a handshake output");

endmodule

bind rgb_conv3x3_filter rgb_c3_checker u_rgb_c3_checker (.*);

FILE: sim/rgb_conv3x3_filter_tb.sv
// ----------------------------------------------------------------------------
// rgb_conv3x3_filter_tb: self-checking testbench of the 3x3 RGB filter
// A directed table covers drain handling and kernel extremes, then random
// frames of random sizes and kernels follow under several idle patterns.
// Every output transfer is compared with a predictor kept in the bench.
// ----------------------------------------------------------------------------
module rgb_conv3x3_filter_tb;
	import rgb_c3_pkg::*;

	localparam int MAXW      = DEF_MAX_WIDTH;
	localparam int FRAC      = DEF_COEF_FRAC_BITS;
	localparam int REG_COUNT = 5;
	localparam int SETTLE    = 20;
	localparam int LIMIT     = 600000;
	localparam int RAND_ITEMS = 1400;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic       last;
		logic       fend;
	} result_t;

	typedef struct {
		logic       f;
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		bit         known;
		result_t    res;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [47:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [7:0]  red, green, blue;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_red, out_green, out_blue;
	logic        last_of_run, frame_end;

	int gap_pct   = 0;
	int stall_pct = 0;
	int errors    = 0;
	int cycles    = 0;
	int items_sent = 0;

	result_t px_expected[$];

	// Filter state as the bench sees it.
	logic [10:0] m_width;
	logic [15:0] m_height;
	logic [47:0] m_ktop, m_kmid, m_kbot;
	pix_t        m_rows[0:3*MAXW-1];
	int          m_row, m_col, m_drain;

	dir_row_t dir_tab[21];

	rgb_conv3x3_filter u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .red(red), .green(green), .blue(blue),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.last_of_run(last_of_run), .frame_end(frame_end)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Random receiver stall.
	always @(posedge clk) begin
		out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);
	end

	function automatic int eff_w();
		if (m_width == 0) return 1;
		if (m_width > MAXW) return MAXW;
		return int'(m_width);
	endfunction

	function automatic int eff_h();
		return (m_height == 0) ? 1 : int'(m_height);
	endfunction

	function automatic pix_t stored_px(int row, int col);
		return m_rows[(row % 3) * MAXW + col];
	endfunction

	function automatic logic signed [15:0] tap(int i, int j);
		logic [47:0] kr;
		kr = (i == 0) ? m_ktop : (i == 1) ? m_kmid : m_kbot;
		return kr[16*j +: 16];
	endfunction

	// Output pixel at (row, col): border passes, interior is convolved.
	function automatic pix_t filter_pixel(int row, int col, int w, int h);
		int   acc[3];
		int   q;
		pix_t p;
		pix_t o;
		if (row < 1 || row + 2 > h || col < 1 || col + 2 > w)
			return stored_px(row, col);
		acc = '{0, 0, 0};
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				p = stored_px(row - 1 + i, col - 1 + j);
				for (int ch = 0; ch < 3; ch++)
					acc[ch] += int'(p[23-8*ch -: 8]) * int'(tap(i, j));
			end
		end
		o = '0;
		for (int ch = 0; ch < 3; ch++) begin
			if (acc[ch] < 0) begin
				q = 0;
			end else begin
				q = acc[ch] >>> FRAC;
				if (q > int'(CH_MAX)) q = int'(CH_MAX);
			end
			o[23-8*ch -: 8] = q[7:0];
		end
		return o;
	endfunction

	function automatic result_t mk_result(pix_t p, logic last, logic fend);
		result_t res;
		res.r = p[23:16];
		res.g = p[15:8];
		res.b = p[7:0];
		res.last = last;
		res.fend = fend;
		return res;
	endfunction

	// Advance the filter state by one input transfer and queue its results.
	task automatic predict_outputs(logic f, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		int  w, h, rr, cc, col;
		bit  row_end;
		w = eff_w();
		h = eff_h();
		if (f == FUNC_DRAIN) begin
			if (m_drain == 0 || m_drain > w) begin
				m_drain = 0;
			end else begin
				col = w - m_drain;
				m_drain--;
				px_expected.push_back(mk_result(filter_pixel(h - 1, col, w, h), 1'b1,
					m_drain == 0));
			end
			return;
		end
		m_drain = 0;
		rr = (m_row >= h) ? h - 1 : m_row;
		cc = (m_col >= w) ? w - 1 : m_col;
		m_rows[(rr % 3) * MAXW + cc] = {r, g, b};
		if (rr >= 1) begin
			row_end = (cc + 1 == w);
			if (cc >= 1)
				px_expected.push_back(mk_result(filter_pixel(rr - 1, cc - 1, w, h),
					!row_end, 1'b0));
			if (row_end)
				px_expected.push_back(mk_result(filter_pixel(rr - 1, cc, w, h), 1'b1, 1'b0));
		end
		if (cc + 1 >= w) begin
			m_col = 0;
			if (rr + 1 >= h) begin
				m_row = 0;
				m_drain = w;
			end else begin
				m_row = rr + 1;
			end
		end else begin
			m_col = cc + 1;
			m_row = rr;
		end
	endtask

	// One input transfer, with random idle cycles ahead of it.
	task automatic send_item(logic f, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		bit first;
		first = 1;
		while (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			if (first) in_valid <= 1'b0;
			first = 0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func  <= f;
		red   <= r;
		green <= g;
		blue  <= b;
		do @(posedge clk); while (in_stall);
		predict_outputs(f, r, g, b);
		items_sent++;
	endtask

	// Lower valid and wait until every expected result has left the block.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (px_expected.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Register write, mirrored into the bench state.
	task automatic write_reg(logic [2:0] idx, logic [47:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_WIDTH:  m_width  = d[10:0];
			REG_HEIGHT: m_height = d[15:0];
			REG_KTOP:   m_ktop   = d;
			REG_KMID:   m_kmid   = d;
			REG_KBOT:   m_kbot   = d;
			default:    ;
		endcase
		if (idx == REG_WIDTH || idx == REG_HEIGHT) begin
			m_row = 0;
			m_col = 0;
			m_drain = 0;
		end
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_chan();
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [47:0] rand_kernel_row();
		logic [47:0] k;
		for (int j = 0; j < 3; j++) begin
			case ($urandom_range(0, 3))
				0: k[16*j +: 16] = 16'($urandom_range(0, 65535));
				1: k[16*j +: 16] = 16'($signed($urandom_range(0, 1024)) - 512);
				2: k[16*j +: 16] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
				default: k[16*j +: 16] = 16'($urandom_range(0, 300));
			endcase
		end
		return k;
	endfunction

	// Whole frames with some stray drains; the drain tail varies in length.
	// A frame cut short by the pixel limit gets only a few stray drains.
	task automatic run_frames(int frames, int pix_limit);
		int w, h, n, nd;
		w = eff_w();
		h = eff_h();
		for (int fr = 0; fr < frames; fr++) begin
			n = w * h;
			if (pix_limit > 0 && n > pix_limit) n = pix_limit;
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 19) == 0)
					send_item(FUNC_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
				send_item(FUNC_PIXEL, rand_chan(), rand_chan(), rand_chan());
			end
			if (n < w * h) begin
				nd = $urandom_range(0, 3);
			end else begin
				nd = ($urandom_range(0, 4) != 0) ? w : $urandom_range(0, w + 2);
			end
			for (int k = 0; k < nd; k++)
				send_item(FUNC_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
		end
	endtask

	// Check every output transfer against the oldest expectation.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (px_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %h %h %h last=%b fend=%b", $time,
					out_red, out_green, out_blue, last_of_run, frame_end);
			end else begin
				want = px_expected.pop_front();
				if (out_red !== want.r) begin
					errors++;
					$display("%0t: out_red expected %h actual %h", $time, want.r, out_red);
				end
				if (out_green !== want.g) begin
					errors++;
					$display("%0t: out_green expected %h actual %h", $time, want.g, out_green);
				end
				if (out_blue !== want.b) begin
					errors++;
					$display("%0t: out_blue expected %h actual %h", $time, want.b, out_blue);
				end
				if (last_of_run !== want.last) begin
					errors++;
					$display("%0t: last_of_run expected %b actual %b", $time, want.last,
						last_of_run);
				end
				if (frame_end !== want.fend) begin
					errors++;
					$display("%0t: frame_end expected %b actual %b", $time, want.fend,
						frame_end);
				end
			end
		end
	end

	initial begin
		int phase;
		int w_val;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_WIDTH;
		cfg_data  <= '0;
		in_valid  <= 1'b0;
		func      <= FUNC_PIXEL;
		red       <= '0;
		green     <= '0;
		blue      <= '0;
		m_width  = 11'd1024;
		m_height = 16'd1;
		m_ktop   = '0;
		m_kmid   = 48'd134217728;
		m_kbot   = '0;
		m_row = 0;
		m_col = 0;
		m_drain = 0;
		foreach (m_rows[i]) m_rows[i] = '0;

		// Single-pixel frames first, then a 3x3 frame under extreme weights.
		dir_tab = '{
			'{FUNC_PIXEL, 8'h00, 8'h00, 8'h00, 0, '0},
			'{FUNC_DRAIN, 8'h00, 8'h00, 8'h00, 1, '{8'h00, 8'h00, 8'h00, 1'b1, 1'b1}},
			'{FUNC_PIXEL, 8'hFF, 8'hFF, 8'hFF, 0, '0},
			'{FUNC_DRAIN, 8'hFF, 8'hFF, 8'hFF, 1, '{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1}},
			'{FUNC_DRAIN, 8'h00, 8'h00, 8'h00, 0, '0},
			'{FUNC_PIXEL, 8'h12, 8'h34, 8'h56, 0, '0},
			'{FUNC_PIXEL, 8'hAB, 8'hCD, 8'hEF, 0, '0},
			'{FUNC_DRAIN, 8'h00, 8'h00, 8'h00, 1, '{8'hAB, 8'hCD, 8'hEF, 1'b1, 1'b1}},
			'{FUNC_PIXEL, 8'hFF, 8'h00, 8'h80, 0, '0},
			'{FUNC_PIXEL, 8'h00, 8'hFF, 8'h01, 0, '0},
			'{FUNC_PIXEL, 8'hFF, 8'hFF, 8'h7F, 0, '0},
			'{FUNC_PIXEL, 8'h00, 8'h00, 8'hFE, 0, '0},
			'{FUNC_PIXEL, 8'hFF, 8'h80, 8'h40, 0, '0},
			'{FUNC_PIXEL, 8'h01, 8'hFF, 8'h00, 0, '0},
			'{FUNC_PIXEL, 8'hFF, 8'h00, 8'hFF, 0, '0},
			'{FUNC_PIXEL, 8'h00, 8'hFF, 8'h00, 0, '0},
			'{FUNC_PIXEL, 8'h80, 8'h7F, 8'hFF, 0, '0},
			'{FUNC_DRAIN, 8'h00, 8'h00, 8'h00, 0, '0},
			'{FUNC_DRAIN, 8'h00, 8'h00, 8'h00, 0, '0},
			'{FUNC_DRAIN, 8'h00, 8'h00, 8'h00, 0, '0},
			'{FUNC_DRAIN, 8'h00, 8'h00, 8'h00, 0, '0}
		};

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_reg(REG_WIDTH, 48'd1);
		write_reg(REG_HEIGHT, 48'd1);
		for (int i = 0; i < 21; i++) begin
			if (i == 8) begin
				wait_idle();
				write_reg(REG_WIDTH, 48'd3);
				write_reg(REG_HEIGHT, 48'd3);
				write_reg(REG_KTOP, {16'h7FFF, 16'h8000, 16'h7FFF});
				write_reg(REG_KMID, {16'h8000, 16'h7FFF, 16'h8000});
				write_reg(REG_KBOT, {16'h0001, 16'hFFFF, 16'h0800});
			end
			send_item(dir_tab[i].f, dir_tab[i].r, dir_tab[i].g, dir_tab[i].b);
			if (dir_tab[i].known) px_expected[$] = dir_tab[i].res;
		end
		wait_idle();

		// Random phases: new sizes and kernel per phase, idle pattern rotates.
		phase = 0;
		items_sent = 0;
		while (items_sent < RAND_ITEMS || phase < 8) begin
			case (phase % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 60; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 60; end
				default: begin gap_pct = 19; stall_pct = 19; end
			endcase
			write_reg(3'(REG_COUNT + $urandom_range(0, 2)), 48'({$urandom, $urandom}));
			write_reg(REG_KTOP, rand_kernel_row());
			write_reg(REG_KMID, rand_kernel_row());
			write_reg(REG_KBOT, rand_kernel_row());
			case (phase)
				1: begin
					// Oversized width register clamps to the full line; the
					// frame stops a few pixels into its second row.
					write_reg(REG_WIDTH, {37'($urandom), 11'd2047});
					write_reg(REG_HEIGHT, 48'd3);
					run_frames(1, 1030);
				end
				2: begin
					write_reg(REG_WIDTH, 48'd1);
					write_reg(REG_HEIGHT, {32'($urandom), 16'hFFFF});
					run_frames(1, 60);
				end
				3: begin
					write_reg(REG_WIDTH, 48'd0);
					write_reg(REG_HEIGHT, 48'd0);
					run_frames(3, 0);
				end
				default: begin
					w_val = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2)
						: $urandom_range(3, 10);
					write_reg(REG_WIDTH, {37'($urandom), 11'(w_val)});
					write_reg(REG_HEIGHT, {32'($urandom), 16'($urandom_range(1, 6))});
					run_frames($urandom_range(1, 3), 0);
				end
			endcase
			wait_idle();
			phase++;
		end

		gap_pct = 0;
		stall_pct = 0;
		wait_idle();
		if (errors == 0 && px_expected.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
